@@ rtl/rlpm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpm_pkg
// Shared types, codes and character constants of the range list parser and
// matcher.
// ---------------------------------------------------------------------------
package rlpm_pkg;

  localparam int MAX_RANGES_DEF = 40;
  localparam int RC_W           = 6;   // width of the reported entry count

  // command codes
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_AL    = 8'h61;
  localparam logic [7:0] CH_FL    = 8'h66;
  localparam logic [7:0] CH_AU    = 8'h41;
  localparam logic [7:0] CH_FU    = 8'h46;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ITEM, PH_LWS, PH_LSIGN, PH_LDIG, PH_LHEX, PH_ALOW, PH_DOT,
    PH_HWS, PH_HSIGN, PH_HDIG, PH_HHEX, PH_AHIGH, PH_DONE, PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC, RX_ZERO, RX_OCT, RX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_STAT_RD, ST_STAT_OUT, ST_SCAN
  } st_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } range_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         char_code;
    logic signed [31:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               pattern_valid;
    logic               match_everything;
    logic               single_value;
    logic signed [31:0] first_low;
    logic [RC_W-1:0]    range_count;
    logic               is_member;
  } out_item_t;

endpackage

@@ rtl/rlpm_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpm_table
// Range table memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rlpm_table #(
  parameter int DEPTH  = rlpm_pkg::MAX_RANGES_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  rlpm_pkg::range_t    wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output rlpm_pkg::range_t    rd_data
);
  import rlpm_pkg::*;

  range_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/rlpm_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpm_parser
// Character-at-a-time pattern parser: number scanning, range assembly and
// table inserts.
// ---------------------------------------------------------------------------
module rlpm_parser #(
  parameter int MAX_RANGES = rlpm_pkg::MAX_RANGES_DEF,
  parameter int ADDR_W     = 6,
  parameter int CNT_W      = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,       // consume one character
  input  logic               end_mark,   // step is the end marker
  input  logic [7:0]         char_code,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output rlpm_pkg::range_t   wr_data,
  output logic [CNT_W-1:0]   count,
  output logic               everything,
  output logic               pat_done
);
  import rlpm_pkg::*;

  phase_t             phase, phase_next, cur;
  radix_t             radix, radix_next;
  logic [31:0]        accum, accum_next;
  logic               neg, neg_next;
  logic signed [31:0] low_hold, low_hold_next;
  logic [CNT_W-1:0]   count_next, cnt_base;
  logic               every_next, done_next;

  logic               is_end;
  logic [7:0]         c;
  logic               c_ws, c_sep, c_dig, c_dash, c_dot, c_sign, c_x;
  logic [3:0]         dval;
  logic               dval_ok, digit_ok;
  logic [4:0]         base;
  logic [36:0]        prod;
  logic [31:0]        acc_sat;
  logic               hex_ph;
  logic signed [31:0] fin_v;
  logic               f_ws, f_dash, f_dot, f_sep, f_end;
  logic               ins;
  logic signed [31:0] ins_lo, ins_hi;

  function automatic logic signed [31:0] num_value(input logic [31:0] m, input logic n);
    logic signed [31:0] r;
    if (n) begin
      r = m[31] ? INT_MIN : -$signed(m);
    end else begin
      r = m[31] ? INT_MAX : $signed(m);
    end
    return r;
  endfunction

  // A zero byte ends the pattern; only end_mark latches pat_done.
  assign is_end = end_mark || (char_code == 8'h00);
  assign c      = is_end ? 8'h00 : char_code;

  assign c_ws   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_sep  = (c == CH_COMMA) || (c == CH_SLASH) || (c == CH_BAR);
  assign c_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_dash = (c == CH_DASH);
  assign c_dot  = (c == CH_DOT);
  assign c_sign = (c == CH_PLUS) || (c == CH_DASH);
  assign c_x    = (c == CH_XL) || (c == CH_XU);

  always_comb begin
    dval    = 4'd0;
    dval_ok = 1'b0;
    if (c_dig) begin
      dval    = 4'(c - CH_ZERO);
      dval_ok = 1'b1;
    end else if ((c >= CH_AL) && (c <= CH_FL)) begin
      dval    = 4'(c - CH_AL + 8'd10);
      dval_ok = 1'b1;
    end else if ((c >= CH_AU) && (c <= CH_FU)) begin
      dval    = 4'(c - CH_AU + 8'd10);
      dval_ok = 1'b1;
    end
  end

  always_comb begin
    unique case (radix)
      RX_DEC:  base = 5'd10;
      RX_HEX:  base = 5'd16;
      default: base = 5'd8;
    endcase
  end

  assign digit_ok = dval_ok && ({1'b0, dval} < base);
  assign prod     = {5'd0, accum} * {32'd0, base} + {33'd0, dval};
  assign acc_sat  = (prod > 37'h0_8000_0000) ? 32'h8000_0000 : prod[31:0];

  // A hex prefix with no digit finishes as zero followed by a stray 'x'.
  assign hex_ph = (phase == PH_LHEX) || (phase == PH_HHEX);
  assign fin_v  = hex_ph ? 32'sd0 : num_value(accum, neg);
  assign f_ws   = !hex_ph && c_ws;
  assign f_dash = !hex_ph && c_dash;
  assign f_dot  = !hex_ph && c_dot;
  assign f_sep  = !hex_ph && c_sep;
  assign f_end  = !hex_ph && is_end;

  always_comb begin
    phase_next    = phase;
    radix_next    = radix;
    accum_next    = accum;
    neg_next      = neg;
    low_hold_next = low_hold;
    count_next    = count;
    every_next    = everything;
    done_next     = pat_done;
    cur           = phase;
    cnt_base      = count;
    ins           = 1'b0;
    ins_lo        = low_hold;
    ins_hi        = low_hold;
    wr_en         = 1'b0;
    if (step) begin
      // first character of a new pattern clears the table
      if (phase == PH_IDLE) begin
        cur        = PH_ITEM;
        cnt_base   = '0;
        every_next = 1'b0;
      end
      phase_next = cur;
      unique case (cur)
        PH_ITEM, PH_LWS, PH_HWS: begin
          if ((cur == PH_ITEM) && (c == CH_STAR)) begin
            ins        = 1'b1;
            ins_lo     = INT_MIN;
            ins_hi     = INT_MAX;
            every_next = 1'b1;
            phase_next = PH_DONE;
          end else begin
            neg_next   = 1'b0;
            accum_next = '0;
            radix_next = RX_DEC;
            if (c_ws) begin
              phase_next = (cur == PH_HWS) ? PH_HWS : PH_LWS;
            end else if (c_sign) begin
              neg_next   = c_dash;
              phase_next = (cur == PH_HWS) ? PH_HSIGN : PH_LSIGN;
            end else if (c_dig) begin
              radix_next = (c == CH_ZERO) ? RX_ZERO : RX_DEC;
              accum_next = {28'd0, dval};
              phase_next = (cur == PH_HWS) ? PH_HDIG : PH_LDIG;
            end else begin
              phase_next = PH_ERR;
            end
          end
        end
        PH_LSIGN, PH_HSIGN: begin
          if (c_dig) begin
            radix_next = (c == CH_ZERO) ? RX_ZERO : RX_DEC;
            accum_next = {28'd0, dval};
            phase_next = (cur == PH_HSIGN) ? PH_HDIG : PH_LDIG;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_LDIG, PH_HDIG, PH_LHEX, PH_HHEX: begin
          if (!hex_ph && (radix == RX_ZERO) && c_x) begin
            radix_next = RX_HEX;
            phase_next = (cur == PH_HDIG) ? PH_HHEX : PH_LHEX;
          end else if (!hex_ph && digit_ok) begin
            accum_next = acc_sat;
            if (radix == RX_ZERO) begin
              radix_next = RX_OCT;
            end
          end else if (hex_ph && dval_ok) begin
            accum_next = {28'd0, dval};
            phase_next = (cur == PH_HHEX) ? PH_HDIG : PH_LDIG;
          end else begin
            if (hex_ph) begin
              accum_next = '0;
            end
            if ((cur == PH_LDIG) || (cur == PH_LHEX)) begin
              // close the low bound
              low_hold_next = fin_v;
              if (f_ws) begin
                phase_next = PH_ALOW;
              end else if (f_dash) begin
                phase_next = PH_HWS;
              end else if (f_dot) begin
                phase_next = PH_DOT;
              end else begin
                ins        = 1'b1;
                ins_lo     = fin_v;
                ins_hi     = fin_v;
                phase_next = f_sep ? PH_ITEM : (f_end ? PH_DONE : PH_ERR);
              end
            end else if (fin_v < low_hold) begin
              phase_next = PH_ERR;
            end else begin
              // close the high bound
              ins    = 1'b1;
              ins_hi = fin_v;
              if (f_ws) begin
                phase_next = PH_AHIGH;
              end else begin
                phase_next = f_sep ? PH_ITEM : (f_end ? PH_DONE : PH_ERR);
              end
            end
          end
        end
        PH_ALOW: begin
          if (c_ws) begin
            phase_next = PH_ALOW;
          end else if (c_dash) begin
            phase_next = PH_HWS;
          end else if (c_dot) begin
            phase_next = PH_DOT;
          end else begin
            ins        = 1'b1;
            phase_next = c_sep ? PH_ITEM : (is_end ? PH_DONE : PH_ERR);
          end
        end
        PH_DOT: begin
          if (c_dot) begin
            phase_next = PH_HWS;
          end else begin
            ins        = 1'b1;
            phase_next = PH_ERR;
          end
        end
        PH_AHIGH: begin
          if (c_ws) begin
            phase_next = PH_AHIGH;
          end else begin
            phase_next = c_sep ? PH_ITEM : (is_end ? PH_DONE : PH_ERR);
          end
        end
        default: begin
          phase_next = cur;
        end
      endcase
      // drop inserts once the table is full
      count_next = cnt_base;
      if (ins && (cnt_base < CNT_W'(MAX_RANGES))) begin
        wr_en      = 1'b1;
        count_next = cnt_base + 1'b1;
      end
      if (end_mark) begin
        done_next  = (phase_next == PH_DONE);
        phase_next = PH_IDLE;
      end
    end
  end

  assign wr_addr = cnt_base[ADDR_W-1:0];
  assign wr_data = '{lo: ins_lo, hi: ins_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      radix      <= RX_DEC;
      accum      <= '0;
      neg        <= 1'b0;
      low_hold   <= '0;
      count      <= '0;
      everything <= 1'b0;
      pat_done   <= 1'b0;
    end else begin
      phase      <= phase_next;
      radix      <= radix_next;
      accum      <= accum_next;
      neg        <= neg_next;
      low_hold   <= low_hold_next;
      count      <= count_next;
      everything <= every_next;
      pat_done   <= done_next;
    end
  end

endmodule

@@ rtl/range_list_parser_matcher.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_list_parser_matcher
// Parses a range list pattern one character per command into a range table
// memory, reports the pattern status on an end marker, and answers
// membership queries by scanning the table.
// ---------------------------------------------------------------------------
// Pattern character: taken on the transfer, busy stays low, no result.
// End marker: result strobe follows ST_STAT_RD (read of entry 0) and ST_STAT_OUT.
// Query: the table memory read port scans the stored ranges one entry per
//   cycle, the result strobe follows the compare of the last registered read,
//   and the next transfer can land on the strobe edge at earliest.
// Reset (synchronous): parser idle, table empty, no result pending. The
//   table memory holds no reset value; only written entries are ever used.
// The receiver cannot stall: each result is flagged by done for one cycle.
// ---------------------------------------------------------------------------
module range_list_parser_matcher #(
  parameter int MAX_RANGES = rlpm_pkg::MAX_RANGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rlpm_pkg::in_item_t  cmd,
  output logic                done,
  output rlpm_pkg::out_item_t result
);
  import rlpm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  st_t                state, state_next;
  logic               accept;
  logic               step;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  range_t             wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  range_t             rd_data;
  logic [CNT_W-1:0]   count;
  logic               everything;
  logic               pat_done;

  // query scan datapath
  logic [CNT_W-1:0]   idx;
  logic               rd_pend;
  logic               hit;
  logic signed [31:0] qv;
  logic               scan_issue;
  logic               scan_fin;
  logic               in_range;

  logic               res_load;
  out_item_t          res_next;

  assign accept = start && !busy;

  // Characters and end markers go straight to the parser on the transfer;
  // the table is never read in that cycle, so reads and writes never collide.
  assign step = accept && ((cmd.op == OP_CHAR) || (cmd.op == OP_END));

  rlpm_parser #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .end_mark   (cmd.op == OP_END),
    .char_code  (cmd.char_code),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .count      (count),
    .everything (everything),
    .pat_done   (pat_done)
  );

  rlpm_table #(
    .DEPTH   (MAX_RANGES),
    .ADDR_W  (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Issue reads while entries remain; finish once the last compare is done.
  assign scan_issue = (state == ST_SCAN) && (idx != count);
  assign scan_fin   = (state == ST_SCAN) && (idx == count) && !rd_pend;
  assign in_range   = (rd_data.lo <= qv) && (qv <= rd_data.hi);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd.op == OP_END)) begin
          state_next = ST_STAT_RD;
        end else if (accept && (cmd.op == OP_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_STAT_RD:  state_next = ST_STAT_OUT;
      ST_STAT_OUT: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and result assembly
  always_comb begin
    busy     = (state != ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = '0;
    res_load = 1'b0;
    res_next = '0;
    unique case (state)
      ST_STAT_RD: begin
        // fetch entry 0 for first_low and the single-value test
        rd_en = 1'b1;
      end
      ST_STAT_OUT: begin
        res_load                  = 1'b1;
        res_next.result_kind      = KIND_STATUS;
        res_next.pattern_valid    = pat_done;
        res_next.match_everything = everything;
        res_next.single_value     = (count == CNT_W'(1)) && (rd_data.lo == rd_data.hi);
        res_next.first_low        = (count != '0) ? rd_data.lo : 32'sd0;
        res_next.range_count      = RC_W'(count);
      end
      ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = idx[ADDR_W-1:0];
        if (scan_fin) begin
          res_load             = 1'b1;
          res_next.result_kind = KIND_QUERY;
          res_next.is_member   = hit;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= res_load;
      rd_pend <= scan_issue;
    end
  end

  // scan index, hit flag and held query value
  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_QUERY)) begin
      idx <= '0;
      hit <= 1'b0;
      qv  <= cmd.query_value;
    end else begin
      if (scan_issue) begin
        idx <= idx + 1'b1;
      end
      if (rd_pend && in_range) begin
        hit <= 1'b1;
      end
    end
  end

  // hold the result for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

endmodule
